FILE: hw/rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants, codes and controller/datapath interface types for the
// sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int LIST_CAPACITY = 256;
	localparam int ELEMENT_WIDTH = 32;
	localparam int ADDR_W        = $clog2(LIST_CAPACITY);
	localparam int CNT_W         = $clog2(LIST_CAPACITY + 1);

	// fixed field widths of the stream items
	localparam int OPCODE_W   = 3;
	localparam int VALUE_W    = 32;
	localparam int POSITION_W = 8;
	localparam int STATUS_W   = 3;
	localparam int FOUND_W    = 8;
	localparam int COUNT_W    = 9;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_HEAD = 3'd0,
		OP_PUSH_TAIL = 3'd1,
		OP_INSERT_AT = 3'd2,
		OP_POP_HEAD  = 3'd3,
		OP_POP_TAIL  = 3'd4,
		OP_REMOVE_AT = 3'd5,
		OP_FIND      = 3'd6,
		OP_NONE      = 3'd7
	} sle_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} sle_status_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture the input item
		logic plan;    // decide status and set up the scan
		logic scan;    // issue reads while elements remain
		logic finish;  // commit and load the output register
	} sle_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} sle_sts_t;

endpackage

FILE: hw/rtl/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Controller: sequences capture, planning, element scan and commit for one
// item at a time.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sle_sts_t sts,
	output sle_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PLAN,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_PLAN;
				end
				S_PLAN: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.scan_done) state_q <= S_FINISH;
				end
				S_FINISH: begin
					// hold until the output register is free
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	assign cmd.plan   = (state_q == S_PLAN);
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.finish = (state_q == S_FINISH) && sts.out_free;

endmodule

FILE: hw/rtl/sle_dpath.sv
// ----------------------------------------------------------------------------
// sle_dpath
// Datapath: element memory, element count, scan pointer with a one-stage
// read pipeline, search compare and the output register.
// ----------------------------------------------------------------------------
module sle_dpath import sle_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sle_cmd_t               cmd,
	output sle_sts_t               sts,
	input  logic [OPCODE_W-1:0]    in_opcode,
	input  logic [VALUE_W-1:0]     in_value,
	input  logic [POSITION_W-1:0]  in_position,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [STATUS_W-1:0]    out_status,
	output logic [FOUND_W-1:0]     out_found_index,
	output logic [COUNT_W-1:0]     out_count
);

	typedef enum logic [1:0] {
		M_NONE,
		M_SHIFT_UP,
		M_SHIFT_DN,
		M_FIND
	} mode_t;

	logic [ELEMENT_WIDTH-1:0] mem [LIST_CAPACITY];

	sle_op_t                  op_q;
	logic [ELEMENT_WIDTH-1:0] val_q;
	logic [POSITION_W-1:0]    pos_q;
	logic [CNT_W-1:0]         count_q;

	mode_t                    mode_q;
	sle_status_t              status_q;
	logic                     ins_q;
	logic                     del_q;
	logic [ADDR_W-1:0]        at_q;
	logic [ADDR_W-1:0]        ptr_q;
	logic [CNT_W-1:0]         rem_q;
	logic                     hit_q;
	logic [ADDR_W-1:0]        found_q;

	logic                     rdv_s1;
	logic [ADDR_W-1:0]        ra_s1;
	logic [ELEMENT_WIDTH-1:0] rd_data_s1;

	logic                     out_valid_q;
	logic [STATUS_W-1:0]      out_status_q;
	logic [FOUND_W-1:0]       out_found_q;
	logic [COUNT_W-1:0]       out_count_q;

	// plan decode
	mode_t                    p_mode;
	sle_status_t              p_status;
	logic                     p_ins;
	logic                     p_del;
	logic [ADDR_W-1:0]        p_at;
	logic [ADDR_W-1:0]        p_ptr;
	logic [CNT_W-1:0]         p_rem;
	logic                     is_full;
	logic                     is_empty;
	logic                     pos_ok;
	logic [CNT_W-1:0]         pos_ext;

	// memory ports
	logic                     rd_en;
	logic                     mem_we;
	logic [ADDR_W-1:0]        mem_wa;
	logic [ELEMENT_WIDTH-1:0] mem_wd;

	assign pos_ext  = CNT_W'(pos_q);
	assign is_full  = (count_q == CNT_W'(LIST_CAPACITY));
	assign is_empty = (count_q == '0);
	assign pos_ok   = (pos_ext < count_q);

	always_comb begin
		p_mode   = M_NONE;
		p_status = ST_OK;
		p_ins    = 1'b0;
		p_del    = 1'b0;
		p_at     = '0;
		p_ptr    = '0;
		p_rem    = '0;
		unique case (op_q)
			OP_PUSH_HEAD, OP_PUSH_TAIL, OP_INSERT_AT: begin
				if (is_full) begin
					p_status = ST_FULL;
				end else if (op_q == OP_INSERT_AT && !pos_ok) begin
					p_status = ST_BADPOS;
				end else begin
					p_ins = 1'b1;
					if (op_q == OP_PUSH_HEAD) p_at = '0;
					else if (op_q == OP_PUSH_TAIL) p_at = ADDR_W'(count_q);
					else p_at = ADDR_W'(pos_q);
					// move elements at..count-1 up, top first
					p_mode = M_SHIFT_UP;
					p_ptr  = ADDR_W'(count_q - CNT_W'(1));
					p_rem  = count_q - CNT_W'(p_at);
				end
			end
			OP_POP_HEAD, OP_POP_TAIL, OP_REMOVE_AT: begin
				if (is_empty) begin
					p_status = ST_EMPTY;
				end else if (op_q == OP_REMOVE_AT && !pos_ok) begin
					p_status = ST_BADPOS;
				end else begin
					p_del = 1'b1;
					if (op_q != OP_POP_TAIL) begin
						p_at   = (op_q == OP_POP_HEAD) ? '0 : ADDR_W'(pos_q);
						// move elements at+1..count-1 down, bottom first
						p_mode = M_SHIFT_DN;
						p_ptr  = p_at + ADDR_W'(1);
						p_rem  = count_q - CNT_W'(1) - CNT_W'(p_at);
					end
				end
			end
			OP_FIND: begin
				p_status = ST_NOTFOUND;
				p_mode   = M_FIND;
				p_ptr    = '0;
				p_rem    = count_q;
			end
			default: begin
				p_status = ST_OK;
			end
		endcase
	end

	assign rd_en = cmd.scan && (rem_q != '0);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = rd_data_s1;
		if (rdv_s1 && mode_q == M_SHIFT_UP) begin
			mem_we = 1'b1;
			mem_wa = ra_s1 + ADDR_W'(1);
		end else if (rdv_s1 && mode_q == M_SHIFT_DN) begin
			mem_we = 1'b1;
			mem_wa = ra_s1 - ADDR_W'(1);
		end else if (cmd.finish && ins_q) begin
			mem_we = 1'b1;
			mem_wa = at_q;
			mem_wd = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (rd_en) rd_data_s1 <= mem[ptr_q];
	end

	// item capture, plan, read address, match index and output registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= sle_op_t'(in_opcode);
			val_q <= in_value[ELEMENT_WIDTH-1:0];
			pos_q <= in_position;
		end
		if (cmd.plan) begin
			mode_q   <= p_mode;
			status_q <= p_status;
			ins_q    <= p_ins;
			del_q    <= p_del;
			at_q     <= p_at;
		end
		if (rd_en) ra_s1 <= ptr_q;
		if (rdv_s1 && mode_q == M_FIND && !hit_q && rd_data_s1 == val_q) begin
			found_q <= ra_s1;
		end
		if (cmd.finish) begin
			out_status_q <= (mode_q == M_FIND) ? (hit_q ? ST_OK : ST_NOTFOUND) : status_q;
			out_found_q  <= (mode_q == M_FIND && hit_q) ? FOUND_W'(found_q) : '0;
			out_count_q  <= COUNT_W'(ins_q ? count_q + CNT_W'(1)
				: del_q ? count_q - CNT_W'(1) : count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rem_q       <= '0;
			ptr_q       <= '0;
			rdv_s1      <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_s1 <= rd_en;
			if (cmd.plan) begin
				ptr_q <= p_ptr;
				rem_q <= p_rem;
				hit_q <= 1'b0;
			end else if (rd_en) begin
				ptr_q <= (mode_q == M_SHIFT_UP) ? ptr_q - ADDR_W'(1) : ptr_q + ADDR_W'(1);
				rem_q <= rem_q - CNT_W'(1);
			end
			if (rdv_s1 && mode_q == M_FIND && rd_data_s1 == val_q) hit_q <= 1'b1;
			if (cmd.finish) begin
				if (ins_q) count_q <= count_q + CNT_W'(1);
				else if (del_q) count_q <= count_q - CNT_W'(1);
			end
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign sts.scan_done = (rem_q == '0) && !rdv_s1;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_found_index = out_found_q;
	assign out_count       = out_count_q;

endmodule

FILE: hw/rtl/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed values with head/tail/positional insert and remove
// and a first-match search; one result item per input item.
// ----------------------------------------------------------------------------
// Throughput: one item at a time, one element moved or compared per cycle,
//   at most 256 elements moved or searched per item; a new item is taken while
//   the previous result waits in the output register.
// Reset: arst_n clears the count and all control; memory needs no clearing.
module sequential_list_engine import sle_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // opcode[2:0], value[34:3], position[42:35]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // status[2:0], found_index[10:3], count[19:11]
);

	sle_cmd_t              cmd;
	sle_sts_t              sts;
	logic [STATUS_W-1:0]   status;
	logic [FOUND_W-1:0]    found_index;
	logic [COUNT_W-1:0]    count;

	sle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sle_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_opcode       (s_axis_tdata[2:0]),
		.in_value        (s_axis_tdata[34:3]),
		.in_position     (s_axis_tdata[42:35]),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_status      (status),
		.out_found_index (found_index),
		.out_count       (count)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - STATUS_W - FOUND_W - COUNT_W){1'b0}},
		count, found_index, status};

	// one item in flight: accept closes the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an item is in progress");

	// a result is only loaded into a free output register
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output register overwritten");

	// count never exceeds capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (count <= COUNT_W'(LIST_CAPACITY)))
		else $error("count above capacity");

	// found index is zero unless the status is ok
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status != ST_OK |-> found_index == '0)
		else $error("found index set on failed operation");

endmodule
